// ===== src/ptr_pkg.sv =====
package ptr_pkg;

    // Default cap on samples emitted for one segment.
    localparam int PTR_MAX_SAMPLES = 64;

    // Reset values of the configuration registers.
    localparam logic [31:0] PTR_STEP_RESET = 32'h0001_0000;
    localparam logic        PTR_SCALAR_EN_RESET = 1'b1;

    // Configuration register indexes.
    localparam logic PTR_REG_TIME_STEP = 1'b0;
    localparam logic PTR_REG_SCALAR_EN = 1'b1;

    // Number of interpolated fields and bits in the fraction.
    localparam int PTR_NUM_FIELDS = 7;
    localparam int PTR_FRAC_W = 16;

    typedef struct packed {
        logic               start_streamer;
        logic        [31:0] point_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] scalar_in;
        logic               inside_cell;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_vx;
        logic signed [31:0] out_vy;
        logic signed [31:0] out_vz;
        logic signed [31:0] out_scalar;
        logic               last_of_run;
        logic               truncated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PREP,
        ST_CHECK,
        ST_DINIT,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       clr_time;
        logic       load_prev;
        logic       run;
        logic       stop;
        logic       prep;
        logic       seg_init;
        logic       div_init;
        logic       div_step;
        logic       mul_prod;
        logic       mul_acc;
        logic [2:0] mul_sel;
        logic       emit;
        logic       finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic is_inside;
        logic stopped;
        logic seg_fwd;
        logic no_sample;
        logic last_sample;
        logic out_free;
    } status_t;

endpackage

// ===== src/ptr_ctrl.sv =====
module ptr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  ptr_pkg::status_t sts,
    output ptr_pkg::cmd_t  cmd,
    output logic           busy
);
    import ptr_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                priority if (sts.is_start || sts.stopped || !sts.is_inside)
                    state_next = ST_IDLE;
                else if (sts.seg_fwd)
                    state_next = ST_PREP;
                else
                    state_next = ST_IDLE;
            end
            ST_PREP:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (sts.no_sample)
                    state_next = ST_IDLE;
                else
                    state_next = ST_DINIT;
            end
            ST_DINIT:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 4'(PTR_FRAC_W - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == 4'(PTR_NUM_FIELDS))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                    state_next = sts.last_sample ? ST_IDLE : ST_DINIT;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // The step counter restarts on every change of state.
    assign cnt_next = (state_next != state_reg) ? '0 : cnt_reg + 4'd1;

    // Commands.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
                cmd.capture = in_valid;
            ST_DECIDE:
            begin
                priority if (sts.is_start)
                begin
                    cmd.clr_time  = 1'b1;
                    cmd.load_prev = sts.is_inside;
                    cmd.run       = sts.is_inside;
                    cmd.stop      = !sts.is_inside;
                end
                else if (sts.stopped)
                    cmd = cmd;
                else if (!sts.is_inside)
                    cmd.stop = 1'b1;
                else if (!sts.seg_fwd)
                    cmd.load_prev = 1'b1;
                else
                    cmd.prep = 1'b1;
            end
            ST_PREP:
                cmd.seg_init = 1'b1;
            ST_CHECK:
                cmd.load_prev = sts.no_sample;
            ST_DINIT:
                cmd.div_init = 1'b1;
            ST_DIV:
                cmd.div_step = 1'b1;
            ST_MUL:
            begin
                cmd.mul_prod = (cnt_reg < 4'(PTR_NUM_FIELDS));
                cmd.mul_acc  = (cnt_reg != 4'd0);
                cmd.mul_sel  = cnt_reg[2:0];
            end
            ST_EMIT:
            begin
                cmd.emit   = sts.out_free;
                cmd.finish = sts.out_free && sts.last_sample;
            end
            default:
                cmd = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== src/ptr_dpath.sv =====
module ptr_dpath #(
    parameter int MAX_SAMPLES_PER_SEGMENT = ptr_pkg::PTR_MAX_SAMPLES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ptr_pkg::in_item_t  in_data,
    input  logic               out_stall,
    output logic               out_valid,
    output ptr_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  ptr_pkg::cmd_t      cmd,
    output ptr_pkg::status_t   sts
);
    import ptr_pkg::*;

    localparam int SPAN_W = 32 + $clog2(MAX_SAMPLES_PER_SEGMENT + 1);
    localparam int LIM_W  = SPAN_W + 2;
    localparam int CNT_W  = (MAX_SAMPLES_PER_SEGMENT > 1) ?
                            $clog2(MAX_SAMPLES_PER_SEGMENT) : 1;
    localparam int PROD_W = 33 + PTR_FRAC_W + 1;

    logic        [31:0]        time_step_reg;
    logic                      scalar_en_reg;
    in_item_t                  cur_reg;
    logic                      stopped_reg;
    logic        [31:0]        prev_time_reg;
    logic signed [31:0]        prev_val_reg [PTR_NUM_FIELDS];
    logic        [32:0]        samp_time_reg;
    logic        [SPAN_W-1:0]  span_reg;
    logic                      cut_reg;
    logic        [CNT_W-1:0]   cnt_reg;
    logic        [31:0]        rem_reg;
    logic        [PTR_FRAC_W-1:0] frac_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic        [2:0]         pidx_reg;
    logic signed [31:0]        res_reg [PTR_NUM_FIELDS];
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic        [31:0]        den;
    logic        [32:0]        rem_sh;
    logic        [32:0]        step_time;
    logic        [LIM_W-1:0]   lim_time;
    logic signed [31:0]        cur_sel;
    logic signed [32:0]        diff;
    logic signed [31:0]        lerp_val;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= PTR_STEP_RESET;
            scalar_en_reg <= PTR_SCALAR_EN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                PTR_REG_TIME_STEP: time_step_reg <= cfg_data;
                PTR_REG_SCALAR_EN: scalar_en_reg <= cfg_data[0];
                default:           time_step_reg <= time_step_reg;
            endcase
        end
    end

    // Segment arithmetic shared by several steps.
    assign den       = cur_reg.point_time - prev_time_reg;
    assign rem_sh    = {rem_reg, 1'b0};
    assign step_time = samp_time_reg + {1'b0, time_step_reg};
    assign lim_time  = LIM_W'(samp_time_reg) + LIM_W'(span_reg);

    // Current value of the field that the multiplier is working on.
    always_comb
    begin
        unique case (cmd.mul_sel)
            3'd0:    cur_sel = cur_reg.pos_x;
            3'd1:    cur_sel = cur_reg.pos_y;
            3'd2:    cur_sel = cur_reg.pos_z;
            3'd3:    cur_sel = cur_reg.vel_x;
            3'd4:    cur_sel = cur_reg.vel_y;
            3'd5:    cur_sel = cur_reg.vel_z;
            default: cur_sel = cur_reg.scalar_in;
        endcase
    end

    assign diff = 33'(cur_sel) - 33'(prev_val_reg[cmd.mul_sel]);

    // An arithmetic shift of the product gives the floor of the scaled step.
    assign lerp_val = prev_val_reg[pidx_reg]
                    + 32'(prod_reg >>> PTR_FRAC_W);

    // Streamer state and the stored previous point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg   <= 1'b1;
            prev_time_reg <= '0;
            samp_time_reg <= '0;
            for (int i = 0; i < PTR_NUM_FIELDS; i++)
                prev_val_reg[i] <= '0;
        end
        else
        begin
            if (cmd.run)
                stopped_reg <= 1'b0;
            if (cmd.stop)
                stopped_reg <= 1'b1;
            if (cmd.clr_time)
                samp_time_reg <= '0;
            if (cmd.emit)
                samp_time_reg <= step_time;
            if (cmd.finish && cut_reg)
                samp_time_reg <= {1'b0, cur_reg.point_time};
            if (cmd.load_prev || cmd.finish)
            begin
                prev_time_reg   <= cur_reg.point_time;
                prev_val_reg[0] <= cur_reg.pos_x;
                prev_val_reg[1] <= cur_reg.pos_y;
                prev_val_reg[2] <= cur_reg.pos_z;
                prev_val_reg[3] <= cur_reg.vel_x;
                prev_val_reg[4] <= cur_reg.vel_y;
                prev_val_reg[5] <= cur_reg.vel_z;
                prev_val_reg[6] <= cur_reg.scalar_in;
            end
        end
    end

    // Input capture, cap check, divider and multiplier.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            cur_reg <= in_data;
        if (cmd.prep)
            span_reg <= SPAN_W'(time_step_reg) * SPAN_W'(MAX_SAMPLES_PER_SEGMENT);
        if (cmd.seg_init)
        begin
            cut_reg <= (lim_time < LIM_W'(cur_reg.point_time));
            cnt_reg <= '0;
        end
        if (cmd.emit)
            cnt_reg <= cnt_reg + CNT_W'(1);
        if (cmd.div_init)
        begin
            // Sample times before the segment clamp the fraction to zero.
            rem_reg  <= (samp_time_reg > {1'b0, prev_time_reg}) ?
                        samp_time_reg[31:0] - prev_time_reg : '0;
            frac_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, den})
            begin
                rem_reg  <= 32'(rem_sh - {1'b0, den});
                frac_reg <= {frac_reg[PTR_FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[31:0];
                frac_reg <= {frac_reg[PTR_FRAC_W-2:0], 1'b0};
            end
        end
        if (cmd.mul_prod)
        begin
            prod_reg <= PROD_W'(diff) * PROD_W'(signed'({1'b0, frac_reg}));
            pidx_reg <= cmd.mul_sel;
        end
        if (cmd.mul_acc)
        begin
            if (pidx_reg == 3'(PTR_NUM_FIELDS - 1) && !scalar_en_reg)
                res_reg[pidx_reg] <= '0;
            else
                res_reg[pidx_reg] <= lerp_val;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.out_x       <= res_reg[0];
            out_data_reg.out_y       <= res_reg[1];
            out_data_reg.out_z       <= res_reg[2];
            out_data_reg.out_vx      <= res_reg[3];
            out_data_reg.out_vy      <= res_reg[4];
            out_data_reg.out_vz      <= res_reg[5];
            out_data_reg.out_scalar  <= res_reg[6];
            out_data_reg.last_of_run <= sts.last_sample;
            out_data_reg.truncated   <= cut_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status for the controller.
    assign sts.is_start    = cur_reg.start_streamer;
    assign sts.is_inside   = cur_reg.inside_cell;
    assign sts.stopped     = stopped_reg;
    assign sts.seg_fwd     = (cur_reg.point_time > prev_time_reg);
    assign sts.no_sample   = (samp_time_reg >= {1'b0, cur_reg.point_time});
    assign sts.last_sample = (cnt_reg == CNT_W'(MAX_SAMPLES_PER_SEGMENT - 1))
                          || ({1'b0, step_time} >= 34'(cur_reg.point_time));
    assign sts.out_free    = !out_valid_reg || !out_stall;

endmodule

// ===== src/polyline_time_resampler.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_stall   in_data  (ptr_pkg::in_item_t)
// out      out_valid / out_stall out_data (ptr_pkg::out_item_t)
// cfg      cfg_we                cfg_index, cfg_data
//
// A point that emits nothing passes the decide step, plus prep and check when it
// closes a segment. Each sample runs a restoring divider for the fraction,
// then one shared multiplier over seven fields, then the emit.
// Reset is asynchronous and active low; the block then waits for a start point.
// A stalled output holds the sample and pauses the next one at the emit step.
module polyline_time_resampler #(
    parameter int MAX_SAMPLES_PER_SEGMENT = ptr_pkg::PTR_MAX_SAMPLES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ptr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ptr_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import ptr_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic    busy;

    // Sequencer.
    ptr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Arithmetic and storage.
    ptr_dpath #(
        .MAX_SAMPLES_PER_SEGMENT (MAX_SAMPLES_PER_SEGMENT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign in_stall = busy;

endmodule

// ===== src/ptr_checker.sv =====
module ptr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input ptr_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input ptr_pkg::out_item_t out_data,
    input logic               cfg_we,
    input logic               cfg_index,
    input logic [31:0]        cfg_data
);
    import ptr_pkg::*;

    // A stalled sample stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled sample changed");

    // An accepted point keeps the input stalled while it is decided.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // The handshake outputs are always driven to known levels.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("handshake output unknown");

    // Nothing is emitted while a new point can be taken.
    a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !in_stall |=> !out_valid)
        else $error("sample emitted while idle");

endmodule

bind polyline_time_resampler ptr_checker u_ptr_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ptr_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    polyline_time_resampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the resampler's registers and trajectory state.
    logic [31:0]        step_q;
    logic               scalar_on_q;
    logic [31:0]        last_time_q;
    logic signed [31:0] last_vals_q [7];
    longint unsigned    sample_time_q;
    logic               halted_q;

    out_item_t pending_samples[$];
    int        mismatches;
    int        cycle_count;
    logic      calm;
    logic      hold_request;
    logic      valid_held;

    always #2 clk = ~clk;

    // Hard limit on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [31:0] blend(logic signed [31:0] a,
                                                 logic signed [31:0] b,
                                                 logic [15:0] r);
        longint d;
        longint s;
        d = (longint'(b) - longint'(a)) * longint'({1'b0, r});
        s = longint'(a) + (d >>> 16);
        return s[31:0];
    endfunction

    function automatic void store_point(in_item_t p);
        last_time_q = p.point_time;
        last_vals_q[0] = p.pos_x;
        last_vals_q[1] = p.pos_y;
        last_vals_q[2] = p.pos_z;
        last_vals_q[3] = p.vel_x;
        last_vals_q[4] = p.vel_y;
        last_vals_q[5] = p.vel_z;
        last_vals_q[6] = p.scalar_in;
    endfunction

    // Works out the samples that one accepted point causes.
    function automatic void resample_point(in_item_t p);
        longint unsigned    t;
        longint unsigned    span;
        longint unsigned    num;
        logic [15:0]        r;
        logic signed [31:0] cur [7];
        logic signed [31:0] res [7];
        out_item_t          s;
        int                 n;
        int                 first;
        t = longint'(p.point_time);
        if (p.start_streamer)
        begin
            sample_time_q = 0;
            if (p.inside_cell)
            begin
                store_point(p);
                halted_q = 1'b0;
            end
            else
                halted_q = 1'b1;
            return;
        end
        if (halted_q)
            return;
        if (!p.inside_cell)
        begin
            halted_q = 1'b1;
            return;
        end
        if (p.point_time > last_time_q)
        begin
            span = t - longint'(last_time_q);
            cur = '{p.pos_x, p.pos_y, p.pos_z, p.vel_x, p.vel_y, p.vel_z, p.scalar_in};
            n = 0;
            first = pending_samples.size();
            while (sample_time_q < t && n < PTR_MAX_SAMPLES)
            begin
                num = 0;
                if (sample_time_q > longint'(last_time_q))
                    num = sample_time_q - longint'(last_time_q);
                r = 16'((num << 16) / span);
                for (int j = 0; j < 7; j++)
                    res[j] = blend(last_vals_q[j], cur[j], r);
                s.out_x = res[0];
                s.out_y = res[1];
                s.out_z = res[2];
                s.out_vx = res[3];
                s.out_vy = res[4];
                s.out_vz = res[5];
                s.out_scalar = scalar_on_q ? res[6] : 32'sd0;
                s.last_of_run = 1'b0;
                s.truncated = 1'b0;
                pending_samples.push_back(s);
                sample_time_q = sample_time_q + longint'(step_q);
                n++;
            end
            if (n > 0)
            begin
                pending_samples[pending_samples.size() - 1].last_of_run = 1'b1;
                if (sample_time_q < t)
                begin
                    for (int k = first; k < pending_samples.size(); k++)
                        pending_samples[k].truncated = 1'b1;
                    sample_time_q = t;
                end
            end
        end
        store_point(p);
    endfunction

    // Sample receiver: checks every accepted item and draws its own stalls.
    initial
    begin
        int        wait_left;
        out_item_t want;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected sample %h", out_data);
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (out_data !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Sample mismatch: expected %h, got %h", want, out_data);
                    end
                end
                wait_left = calm ? 0 : $urandom_range(0, 12);
            end
            if (hold_request)
            begin
                wait_left = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Offers one point and predicts its samples once it is accepted.
    task automatic send_point(in_item_t p);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0 && valid_held)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        if (gap > 0)
            repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data <= p;
        valid_held = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        resample_point(p);
    endtask

    task automatic release_input();
        if (valid_held)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    task automatic wait_drained();
        release_input();
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == PTR_REG_TIME_STEP)
            step_q = value;
        else
            scalar_on_q = value[0];
        @(posedge clk);
    endtask

    function automatic in_item_t make_point(logic first, logic in_cell, logic [31:0] t);
        in_item_t p;
        p.start_streamer = first;
        p.point_time = t;
        p.pos_x = $urandom;
        p.pos_y = $urandom;
        p.pos_z = $urandom;
        p.vel_x = $urandom;
        p.vel_y = $urandom;
        p.vel_z = $urandom;
        p.scalar_in = $urandom;
        p.inside_cell = in_cell;
        return p;
    endfunction

    function automatic in_item_t uniform_point(logic first, logic [31:0] t,
                                               logic signed [31:0] v);
        in_item_t p;
        p = make_point(first, 1'b1, t);
        p.pos_x = v;
        p.pos_y = v;
        p.pos_z = v;
        p.vel_x = v;
        p.vel_y = v;
        p.vel_z = v;
        p.scalar_in = v;
        return p;
    endfunction

    // Extremes of the fields and each special case of the resampler.
    task automatic test_special_cases();
        // A point before any start is ignored.
        send_point(make_point(1'b0, 1'b1, 32'h0002_0000));
        // Full-scale swing from the most negative to the most positive value.
        send_point(uniform_point(1'b1, 32'h0, 32'sh8000_0000));
        send_point(uniform_point(1'b0, 32'h0004_0000, 32'sh7FFF_FFFF));
        send_point(uniform_point(1'b0, 32'h0006_8000, 32'sh8000_0000));
        // Zero-length and backward segments only store the point.
        send_point(make_point(1'b0, 1'b1, 32'h0006_8000));
        send_point(make_point(1'b0, 1'b1, 32'h0003_0000));
        send_point(make_point(1'b0, 1'b1, 32'h0009_0000));
        // Leaving the cell stops the streamer; later points are ignored.
        send_point(make_point(1'b0, 1'b0, 32'h000A_0000));
        send_point(make_point(1'b0, 1'b1, 32'h000C_0000));
        // A start outside a cell keeps it stopped.
        send_point(make_point(1'b1, 1'b0, 32'h0));
        send_point(make_point(1'b0, 1'b1, 32'h0002_0000));
        // Streamer starting late: early sample times clamp to the first point.
        send_point(make_point(1'b1, 1'b1, 32'h0005_0000));
        send_point(make_point(1'b0, 1'b1, 32'h0007_8000));
        // A segment longer than the cap allows is truncated.
        send_point(make_point(1'b0, 1'b1, 32'h006E_0000));
        send_point(make_point(1'b0, 1'b1, 32'h006E_8000));
        // Largest time in the field.
        send_point(make_point(1'b0, 1'b1, 32'hFFFF_FFFF));
        send_point(make_point(1'b1, 1'b1, 32'hFFFF_FFF0));
        send_point(make_point(1'b0, 1'b1, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    // One streamer whose segments span a few time steps each.
    task automatic run_streamer(int points, int max_steps);
        longint unsigned t;
        longint unsigned inc;
        t = $urandom_range(0, 3) == 0 ? 0 : longint'($urandom_range(0, 32'h00FF_FFFF));
        send_point(make_point(1'b1, 1'b1, t[31:0]));
        for (int i = 1; i < points; i++)
        begin
            inc = longint'(step_q) * $urandom_range(0, max_steps)
                  + longint'($urandom_range(0, 32'hFFFF)) * longint'(step_q) / 65536;
            if ($urandom_range(0, 15) == 0)
                inc = 0;
            t = t + inc;
            if (t > 64'hFFFF_FFFF)
                return;
            send_point(make_point(1'b0, $urandom_range(0, 19) != 0, t[31:0]));
        end
    endtask

    task automatic test_step_extremes();
        // Smallest step: every long segment runs into the cap.
        write_reg(PTR_REG_TIME_STEP, 32'd1);
        send_point(make_point(1'b1, 1'b1, 32'h0));
        send_point(make_point(1'b0, 1'b1, 32'd30));
        send_point(make_point(1'b0, 1'b1, 32'd200));
        // Scalar disabled.
        write_reg(PTR_REG_SCALAR_EN, 32'd0);
        send_point(make_point(1'b0, 1'b1, 32'd230));
        write_reg(PTR_REG_SCALAR_EN, 32'd1);
        // Largest step: one sample, after which the sample time is at its maximum.
        write_reg(PTR_REG_TIME_STEP, 32'hFFFF_FFFF);
        send_point(make_point(1'b1, 1'b1, 32'h0));
        send_point(make_point(1'b0, 1'b1, 32'h1234_5678));
        send_point(make_point(1'b0, 1'b1, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while points keep coming.
    task automatic test_output_hold();
        write_reg(PTR_REG_TIME_STEP, 32'h0000_8000);
        hold_request = 1'b1;
        calm = 1'b1;
        run_streamer(12, 3);
        calm = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_streamers();
        logic [31:0] steps [4];
        steps = '{32'h0001_0000, 32'h0000_0400, 32'h0123_4567, 32'h8000_0001};
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(PTR_REG_TIME_STEP,
                      phase < 4 ? steps[phase] : $urandom_range(1, 32'h00FF_FFFF));
            write_reg(PTR_REG_SCALAR_EN, $urandom_range(0, 1));
            calm = (phase == 2);
            for (int s = 0; s < 6; s++)
            begin
                int pts;
                pts = $urandom_range(2, 8);
                run_streamer(pts, 4);
                // Some noise: raw points of any kind.
                if ($urandom_range(0, 2) == 0)
                    send_point(make_point(1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)), $urandom));
                // Sender pauses until every sample has come.
                if (s == 3)
                    wait_drained();
            end
        end
        calm = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = PTR_REG_TIME_STEP;
        cfg_data = '0;
        cycle_count = 0;
        mismatches = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        valid_held = 1'b0;
        step_q = PTR_STEP_RESET;
        scalar_on_q = PTR_SCALAR_EN_RESET;
        last_time_q = '0;
        for (int j = 0; j < 7; j++)
            last_vals_q[j] = '0;
        sample_time_q = 0;
        halted_q = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_step_extremes();
        test_output_hold();
        test_random_streamers();
        wait_drained();

        if (mismatches == 0 && pending_samples.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
